[rtl/core/mpof_pkg.sv]
package mpof_pkg;

    // Fixed register and field widths
    localparam int PATTERN_W  = 48;
    localparam int LIMIT_W    = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int REPORT_W   = 32;

    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 48'h3635_3433_3231;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 5'd20;
    localparam logic [LIMIT_W-1:0]   HARD_LIMIT    = 5'd20;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MARKER_PATTERN = 1'b0,
        CFG_MAX_MATCHES    = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        KIND_MATCH   = 1'b0,
        KIND_SUMMARY = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t          kind;
        logic [REPORT_W-1:0]   offset;
        logic [LIMIT_W-1:0]    count;
        logic                  limit_reached;
        logic                  is_last;
    } result_t;

    // Up to two results pushed per input transfer, rec0 first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    rec0;
        result_t    rec1;
    } result_push_t;

endpackage

[rtl/core/mpof_matcher.sv]
module mpof_matcher
    import mpof_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int MARKER_LEN  = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [PATTERN_W-1:0]  cfg_wdata,
    input  logic                  in_xfer,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_file,
    input  logic                  last_of_file,
    output result_push_t          push
);

    localparam logic [3:0] LEN4     = 4'(MARKER_LEN);
    localparam logic [2:0] LAST_IDX = 3'(MARKER_LEN - 1);

    logic [PATTERN_W-1:0]   pattern_reg;
    logic [LIMIT_W-1:0]     max_reg;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] cand_reg, cand_next;
    logic [2:0]             prog_reg, prog_next;
    logic [LIMIT_W-1:0]     found_reg, found_next;
    logic                   stop_reg, stop_next;

    logic [LIMIT_W-1:0]     lim;
    logic [63:0]            marker_ext;
    logic [OFFSET_BITS-1:0] pos_cur, cand_cur;
    logic [2:0]             prog_cur, p_idx;
    logic [LIMIT_W-1:0]     found_cur;
    logic                   stop_cur;
    logic [2:0]             sel_idx;
    logic [7:0]             mb_p, mb_0;
    logic [3:0]             p_next;
    logic                   hit;
    result_t                hit_rec, sum_rec;

    // Effective match limit, clamped to 1..20
    always_comb begin
        lim = max_reg;
        if (lim == '0) begin
            lim = LIMIT_W'(1);
        end else if (lim > HARD_LIMIT) begin
            lim = HARD_LIMIT;
        end
    end

    // Marker byte k sits at byte MARKER_LEN-1-k; bytes above bit 47 read zero
    assign marker_ext = {{(64 - PATTERN_W){1'b0}}, pattern_reg};
    assign sel_idx    = LAST_IDX - p_idx;
    assign mb_p       = marker_ext[{sel_idx, 3'b000} +: 8];
    assign mb_0       = marker_ext[{LAST_IDX, 3'b000} +: 8];

    // A first byte clears the per-file state before it is scanned
    assign pos_cur   = first_of_file ? '0 : pos_reg;
    assign cand_cur  = first_of_file ? '0 : cand_reg;
    assign prog_cur  = first_of_file ? '0 : prog_reg;
    assign found_cur = first_of_file ? '0 : found_reg;
    assign stop_cur  = first_of_file ? 1'b0 : (stop_reg | (found_reg >= lim));
    assign p_idx     = ({1'b0, prog_cur} >= LEN4) ? 3'd0 : prog_cur;

    // Scan step for one byte
    always_comb begin
        cand_next  = cand_cur;
        found_next = found_cur;
        stop_next  = stop_cur | (found_cur >= lim);
        prog_next  = prog_cur;
        p_next     = 4'd0;
        hit        = 1'b0;
        if (!stop_next) begin
            if (data_byte == mb_p) begin
                if (p_idx == 3'd0) begin
                    cand_next = pos_cur;
                end
                p_next = {1'b0, p_idx} + 4'd1;
            end else if (data_byte == mb_0) begin
                // restart the partial match at this byte
                cand_next = pos_cur;
                p_next    = 4'd1;
            end
            if (p_next >= LEN4) begin
                hit        = 1'b1;
                found_next = found_cur + LIMIT_W'(1);
                p_next     = 4'd0;
                if ((found_cur + LIMIT_W'(1)) >= lim) begin
                    stop_next = 1'b1;
                end
            end
            prog_next = p_next[2:0];
        end
        pos_next = pos_cur + OFFSET_BITS'(1);
    end

    // Result records
    always_comb begin
        hit_rec.kind          = KIND_MATCH;
        hit_rec.offset        = REPORT_W'(cand_next);
        hit_rec.count         = found_next;
        hit_rec.limit_reached = found_next >= lim;
        hit_rec.is_last       = !last_of_file;

        sum_rec.kind          = KIND_SUMMARY;
        sum_rec.offset        = '0;
        sum_rec.count         = found_next;
        sum_rec.limit_reached = found_next >= lim;
        sum_rec.is_last       = 1'b1;

        push.cnt  = 2'd0;
        push.rec0 = hit ? hit_rec : sum_rec;
        push.rec1 = sum_rec;
        if (in_xfer) begin
            push.cnt = {1'b0, hit} + {1'b0, last_of_file};
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= PATTERN_RESET;
            max_reg     <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MARKER_PATTERN: pattern_reg <= cfg_wdata;
                CFG_MAX_MATCHES:    max_reg     <= cfg_wdata[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Scan state; a last byte leaves the state cleared for the next file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cand_reg  <= '0;
            prog_reg  <= '0;
            found_reg <= '0;
            stop_reg  <= 1'b0;
        end else if (in_xfer) begin
            if (last_of_file) begin
                pos_reg   <= '0;
                cand_reg  <= '0;
                prog_reg  <= '0;
                found_reg <= '0;
                stop_reg  <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
                prog_reg  <= prog_next;
                found_reg <= found_next;
                stop_reg  <= stop_next;
            end
        end
    end

endmodule

[rtl/core/mpof_rslt_fifo.sv]
module mpof_rslt_fifo
    import mpof_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  result_push_t push,
    output logic         room_two,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_rec
);

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   pop;

    assign out_valid = cnt_reg != '0;
    assign out_rec   = mem[rd_ptr_reg];
    assign room_two  = cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign pop       = out_valid && out_ready;

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage: up to two entries written per transfer
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.rec0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.rec1;
        end
    end

endmodule

[rtl/core/marker_pattern_offset_finder.sv]
// A result is written into the result queue when the input byte transfers
// and is offered on m_ from the queue. The block takes one byte per cycle
// while the four-entry result queue has two entries free; a byte that
// yields both a match and a summary pushes two entries.
// Reset: synchronous active-low aresetn clears scan state and the queue and
// loads marker "654321" and a limit of 20.
module marker_pattern_offset_finder
    import mpof_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int MARKER_LEN  = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [PATTERN_W-1:0]  cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // first_of_file
    input  logic                  s_tlast,   // last_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [31:0] match_offset, [36:32] match_count,
                                             // [37] limit_reached, [39:38] zero
    output logic                  m_tuser,   // result_kind
    output logic                  m_tlast    // is_last
);

    result_push_t push;
    result_t      out_rec;
    logic         room_two;
    logic         in_xfer;

    assign s_tready = room_two;
    assign in_xfer  = s_tvalid && s_tready;

    mpof_matcher #(
        .OFFSET_BITS (OFFSET_BITS),
        .MARKER_LEN  (MARKER_LEN)
    ) u_matcher (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_xfer       (in_xfer),
        .data_byte     (s_tdata),
        .first_of_file (s_tuser),
        .last_of_file  (s_tlast),
        .push          (push)
    );

    mpof_rslt_fifo u_rslt_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    // Pack the result record onto the master side
    assign m_tdata = {2'b00, out_rec.limit_reached, out_rec.count, out_rec.offset};
    assign m_tuser = out_rec.kind;
    assign m_tlast = out_rec.is_last;

endmodule

[verif/mpof_checker.sv]
module mpof_checker
    import mpof_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [PATTERN_W-1:0]  cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // first_of_file
    input  logic                  s_tlast,   // last_of_file
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // [31:0] match_offset, [36:32] match_count,
                                             // [37] limit_reached, [39:38] zero
    input  logic                  m_tuser,   // result_kind
    input  logic                  m_tlast,   // is_last
    output int                    fail_cnt,
    output int                    open_cnt
);

    localparam int MARK_LEN  = 6;

    // Shadow copy of the registers and the per-file scan state
    logic [PATTERN_W-1:0] marker_q;
    logic [LIMIT_W-1:0]   limit_q;
    logic [31:0]          pos_q;
    logic [31:0]          start_q;
    logic [2:0]           progress_q;
    logic [LIMIT_W-1:0]   found_q;
    logic                 stopped_q;

    // Results predicted but not yet seen on m_, oldest first
    result_t pending_reports[$];
    int      errors = 0;

    function automatic logic [7:0] marker_byte(input int k);
        return marker_q[8*(MARK_LEN-1-k) +: 8];
    endfunction

    // Programmed limit clamped to 1..HARD_LIMIT
    function automatic logic [LIMIT_W-1:0] active_limit();
        if (limit_q == '0) begin
            return LIMIT_W'(1);
        end
        if (limit_q > HARD_LIMIT) begin
            return HARD_LIMIT;
        end
        return limit_q;
    endfunction

    function automatic result_t make_result(input result_kind_t kind, input logic [31:0] off);
        result_t r;
        r.kind          = kind;
        r.offset        = off;
        r.count         = found_q;
        r.limit_reached = (found_q >= active_limit());
        r.is_last       = 1'b0;
        return r;
    endfunction

    task automatic clear_file();
        pos_q      = '0;
        start_q    = '0;
        progress_q = '0;
        found_q    = '0;
        stopped_q  = 1'b0;
    endtask

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got 0x%0h, want 0x%0h", what, got, want));
        end
    endtask

    // Advance the scan by one byte and queue the results it causes
    task automatic scan_byte(input logic [7:0] b, input logic first_flag,
                             input logic last_flag);
        result_t     r[2];
        int          n;
        logic [2:0]  p;
        n = 0;
        if (first_flag) begin
            clear_file();
        end
        if (found_q >= active_limit()) begin
            stopped_q = 1'b1;
        end
        if (!stopped_q) begin
            p = progress_q;
            if (p >= MARK_LEN) begin
                p = '0;
            end
            if (b == marker_byte(p)) begin
                if (p == 0) begin
                    start_q = pos_q;
                end
                p++;
            end else if (b == marker_byte(0)) begin
                // restart the partial match at this byte
                start_q = pos_q;
                p = 3'd1;
            end else begin
                p = '0;
            end
            if (p >= MARK_LEN) begin
                found_q++;
                r[n] = make_result(KIND_MATCH, start_q);
                n++;
                p = '0;
                if (found_q >= active_limit()) begin
                    stopped_q = 1'b1;
                end
            end
            progress_q = p;
        end
        pos_q++;
        if (last_flag) begin
            r[n] = make_result(KIND_SUMMARY, 32'd0);
            n++;
            clear_file();
        end
        if (n > 0) begin
            r[n-1].is_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_reports.push_back(r[i]);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (pending_reports.size() == 0) begin
            report($sformatf("result transfer with nothing pending, tdata 0x%0h", m_tdata));
        end else begin
            want = pending_reports.pop_front();
            check_field("result_kind", 32'(m_tuser), 32'(want.kind));
            check_field("match_offset", m_tdata[31:0], want.offset);
            check_field("match_count", 32'(m_tdata[36:32]), 32'(want.count));
            check_field("limit_reached", 32'(m_tdata[37]), 32'(want.limit_reached));
            check_field("tdata pad", 32'(m_tdata[39:38]), 32'd0);
            check_field("is_last", 32'(m_tlast), 32'(want.is_last));
        end
    endtask

    // Results are checked before the byte of the same edge is scanned: a
    // result on m_ always belongs to an earlier byte.
    always @(posedge aclk) begin
        if (!aresetn) begin
            marker_q = PATTERN_RESET;
            limit_q  = LIMIT_RESET;
            clear_file();
            pending_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tuser, s_tlast);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MARKER_PATTERN: marker_q = cfg_wdata;
                    CFG_MAX_MATCHES:    limit_q  = cfg_wdata[LIMIT_W-1:0];
                    default:            ;
                endcase
            end
        end
        fail_cnt <= errors;
        open_cnt <= pending_reports.size();
    end

endmodule

[verif/tb_top.sv]
module tb_top
    import mpof_pkg::*;
();

    localparam int RANDOM_BYTES = 1900;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [PATTERN_W-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tuser   = 1'b0; // first_of_file
    logic                  s_tlast   = 1'b0; // last_of_file
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;          // [31:0] match_offset, [36:32] match_count,
                                             // [37] limit_reached, [39:38] zero
    logic                  m_tuser;          // result_kind
    logic                  m_tlast;          // is_last

    int                    fail_cnt;
    int                    open_cnt;
    int                    bytes_sent  = 0;
    bit                    src_steady  = 1'b0;
    bit                    snk_steady  = 1'b0;
    logic [PATTERN_W-1:0]  marker_now  = PATTERN_RESET;

    marker_pattern_offset_finder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    mpof_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_cnt  (fail_cnt),
        .open_cnt  (open_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall before each transfer, none while snk_steady is set
    initial begin : result_sink
        int stall;
        forever begin
            stall = snk_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [7:0] mark_at(input int k);
        return marker_now[8*(5-k) +: 8];
    endfunction

    // One byte transfer, after a random gap, none while src_steady is set
    task automatic send_byte(input logic [7:0] b, input logic first_flag,
                             input logic last_flag);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first_flag;
        s_tlast  <= last_flag;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_marker(input int from_k, input int to_k, input logic last_on_end);
        for (int k = from_k; k <= to_k; k++) begin
            send_byte(mark_at(k), 1'b0, last_on_end && (k == to_k));
        end
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_cnt != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [PATTERN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_MARKER_PATTERN) begin
            marker_now = val;
        end
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 5'd1;
            1:       return 5'd20;
            2:       return 5'd0;
            3:       return 5'd31;
            default: return LIMIT_W'($urandom_range(1, 20));
        endcase
    endfunction

    // One file of marker runs, partial markers and filler, with
    // occasional stray first/last flags and mid-file limit changes
    task automatic run_file();
        logic [7:0] body[$];
        int         len;
        int         cut;
        logic       first_flag;
        logic       last_flag;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 40);
        while (body.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (int k = 0; k < 6; k++) body.push_back(mark_at(k));
                end
                3: begin
                    cut = $urandom_range(1, 5);
                    for (int k = 0; k < cut; k++) body.push_back(mark_at(k));
                end
                4:       body.push_back(mark_at($urandom_range(0, 5)));
                5:       body.push_back(mark_at(0));
                default: body.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        for (int i = 0; i < body.size(); i++) begin
            if ($urandom_range(0, 299) == 0) begin
                settle();
                write_reg(CFG_MAX_MATCHES, pick_limit());
            end
            if (i == 0) begin
                first_flag = ($urandom_range(0, 9) != 0);
            end else begin
                first_flag = ($urandom_range(0, 99) == 0);
            end
            if (i == body.size() - 1) begin
                last_flag = ($urandom_range(0, 9) != 0);
            end else begin
                last_flag = ($urandom_range(0, 149) == 0);
            end
            send_byte(body[i], first_flag, last_flag);
        end
    endtask

    initial begin : stimulus
        logic [PATTERN_W-1:0] pat;
        logic [7:0]           fill;
        int                   phase_end;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: mismatch recheck, match on the last byte, extremes
        send_byte(8'h00, 1'b1, 1'b0);
        send_marker(0, 1, 1'b0);
        send_marker(0, 5, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // new file right after a summary, without a first flag
        send_marker(0, 5, 1'b0);
        // limit lowered mid-file to the count: scan stops
        settle();
        write_reg(CFG_MAX_MATCHES, 5'd1);
        send_marker(0, 5, 1'b1);

        // Random phases, each with its own marker, limit and idling mix
        while (bytes_sent < RANDOM_BYTES) begin
            settle();
            fill = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       pat = PATTERN_RESET;
                1:       pat = '0;
                2:       pat = '1;
                3:       pat = {6{fill}};
                default: pat = PATTERN_W'({$urandom, $urandom});
            endcase
            write_reg(CFG_MARKER_PATTERN, pat);
            write_reg(CFG_MAX_MATCHES, pick_limit());
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            phase_end  = bytes_sent + $urandom_range(100, 300);
            while (bytes_sent < phase_end && bytes_sent < RANDOM_BYTES) begin
                run_file();
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && open_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
